[hdl/tvf_pkg.sv]
// ----------------------------------------------------------------------------
// tvf_pkg
// Shared types, character codes and register indexes of the text view filter.
// ----------------------------------------------------------------------------
package tvf_pkg;

  localparam int DefaultDigits = 6;
  localparam int CounterBits   = 20;
  localparam int QueueDepth    = 4;

  localparam int RegCount     = 6;
  localparam int AddrBits     = $clog2(RegCount * 4);
  localparam int RegIndexBits = AddrBits - 2;

  localparam logic [RegIndexBits-1:0] RegNumberAll      = RegIndexBits'(0);
  localparam logic [RegIndexBits-1:0] RegNumberNonblank = RegIndexBits'(1);
  localparam logic [RegIndexBits-1:0] RegSqueezeBlank   = RegIndexBits'(2);
  localparam logic [RegIndexBits-1:0] RegMarkLineEnds   = RegIndexBits'(3);
  localparam logic [RegIndexBits-1:0] RegShowTabs       = RegIndexBits'(4);
  localparam logic [RegIndexBits-1:0] RegShowNonprint   = RegIndexBits'(5);

  localparam logic [7:0] CharTab    = 8'd9;
  localparam logic [7:0] CharNl     = 8'd10;
  localparam logic [7:0] CharSpace  = 8'd32;
  localparam logic [7:0] CharDollar = 8'd36;
  localparam logic [7:0] CharDash   = 8'd45;
  localparam logic [7:0] CharZero   = 8'd48;
  localparam logic [7:0] CharQuery  = 8'd63;
  localparam logic [7:0] CharOffset = 8'd64;
  localparam logic [7:0] CharI      = 8'd73;
  localparam logic [7:0] CharM      = 8'd77;
  localparam logic [7:0] CharCaret  = 8'd94;
  localparam logic [7:0] CharDel    = 8'd127;
  localparam logic [7:0] CharMeta   = 8'd128;
  localparam logic [7:0] CharHigh   = 8'd160;

  typedef struct packed {
    logic number_all_lines;
    logic number_nonblank_lines;
    logic squeeze_blank;
    logic mark_line_ends;
    logic show_tabs;
    logic show_nonprinting;
  } cfg_t;

  function automatic longint counter_cap(input int digits);
    longint p;
    p = 1;
    for (int i = 0; i < digits; i++) begin
      p = p * 10;
    end
    p = p - 1;
    if (p > (longint'(1) << CounterBits) - 1) begin
      p = (longint'(1) << CounterBits) - 1;
    end
    return p;
  endfunction

endpackage

[hdl/tvf_queue.sv]
// ----------------------------------------------------------------------------
// tvf_queue
// Short first-in first-out queue of classified items between front and back.
// ----------------------------------------------------------------------------
module tvf_queue
  import tvf_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = QueueDepth
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PtrBits   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CountBits = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]     entries [DEPTH];
  logic [PtrBits-1:0]   wr_ptr;
  logic [PtrBits-1:0]   rd_ptr;
  logic [CountBits-1:0] count;
  logic                 do_push;
  logic                 do_pop;

  assign full    = (count == CountBits'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrBits'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrBits'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[hdl/tvf_front.sv]
// ----------------------------------------------------------------------------
// tvf_front
// Accepts text bytes, keeps the line state and counter, and turns each byte
// into a descriptor of the display bytes that it causes.
// ----------------------------------------------------------------------------
module tvf_front
  import tvf_pkg::*;
#(
  parameter int NUMBER_DIGITS = DefaultDigits,
  parameter int SLOTS         = NUMBER_DIGITS + 6,
  parameter int DESC_BITS     = SLOTS + 8 * NUMBER_DIGITS + 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cfg_t                 cfg,
  input  logic                 accept,
  input  logic [7:0]           in_byte,
  input  logic                 first_of_file,
  output logic                 desc_push,
  output logic [DESC_BITS-1:0] desc
);

  localparam int SlotTab    = NUMBER_DIGITS;
  localparam int SlotDollar = NUMBER_DIGITS + 1;
  localparam int SlotM      = NUMBER_DIGITS + 2;
  localparam int SlotDash   = NUMBER_DIGITS + 3;
  localparam int SlotCaret  = NUMBER_DIGITS + 4;
  localparam int SlotFinal  = NUMBER_DIGITS + 5;
  localparam logic [CounterBits-1:0] Cap = CounterBits'(counter_cap(NUMBER_DIGITS));

  logic                         prev_was_newline;
  logic                         blank_line_seen;
  logic [CounterBits-1:0]       line_counter;
  logic [4*NUMBER_DIGITS-1:0]   line_bcd;

  logic                         prev_was_newline_next;
  logic                         blank_line_seen_next;
  logic [CounterBits-1:0]       line_counter_next;
  logic [4*NUMBER_DIGITS-1:0]   line_bcd_next;

  logic                         pwn;
  logic                         bls;
  logic [CounterBits-1:0]       cnt;
  logic [4*NUMBER_DIGITS-1:0]   bcd;
  logic [4*NUMBER_DIGITS-1:0]   bcd_inc;
  logic                         is_nl;
  logic                         is_tab;
  logic                         squeeze;
  logic                         numbered;
  logic                         pre_m;
  logic                         pre_caret;
  logic [7:0]                   final_byte;
  logic [SLOTS-1:0]             mask;
  logic [8*NUMBER_DIGITS-1:0]   digit_bytes;
  logic                         carry;
  logic                         seen_nz;
  logic [3:0]                   dig;

  always_comb begin
    pwn    = first_of_file ? 1'b1 : prev_was_newline;
    bls    = first_of_file ? 1'b0 : blank_line_seen;
    cnt    = first_of_file ? CounterBits'(1) : line_counter;
    bcd    = first_of_file ? (4*NUMBER_DIGITS)'(1) : line_bcd;
    is_nl  = (in_byte == CharNl);
    is_tab = (in_byte == CharTab);

    squeeze  = cfg.squeeze_blank && is_nl && pwn && bls;
    numbered = pwn && ((cfg.number_all_lines && !cfg.number_nonblank_lines) ||
                       (cfg.number_nonblank_lines && !is_nl));

    pre_m      = 1'b0;
    pre_caret  = 1'b0;
    final_byte = in_byte;
    if (cfg.show_tabs && is_tab) begin
      pre_caret  = 1'b1;
      final_byte = CharI;
    end else if (cfg.show_nonprinting && !is_nl && !is_tab) begin
      if (in_byte >= CharMeta && in_byte < CharHigh) begin
        pre_m      = 1'b1;
        final_byte = in_byte - CharOffset;
      end else if (in_byte < CharSpace) begin
        pre_caret  = 1'b1;
        final_byte = in_byte + CharOffset;
      end else if (in_byte == CharDel) begin
        pre_caret  = 1'b1;
        final_byte = CharQuery;
      end
    end

    seen_nz     = 1'b0;
    digit_bytes = '0;
    for (int k = NUMBER_DIGITS - 1; k >= 0; k--) begin
      dig     = bcd[4*k +: 4];
      seen_nz = seen_nz || (dig != 4'd0);
      digit_bytes[8*(NUMBER_DIGITS-1-k) +: 8] = seen_nz ? (CharZero + {4'd0, dig}) : CharSpace;
    end

    carry   = 1'b1;
    bcd_inc = bcd;
    for (int k = 0; k < NUMBER_DIGITS; k++) begin
      if (carry) begin
        if (bcd[4*k +: 4] == 4'd9) begin
          bcd_inc[4*k +: 4] = 4'd0;
        end else begin
          bcd_inc[4*k +: 4] = bcd[4*k +: 4] + 4'd1;
          carry = 1'b0;
        end
      end
    end

    mask                  = '0;
    mask[SlotTab-1:0]     = {NUMBER_DIGITS{numbered}};
    mask[SlotTab]         = numbered;
    mask[SlotDollar]      = cfg.mark_line_ends && is_nl;
    mask[SlotM]           = pre_m;
    mask[SlotDash]        = pre_m;
    mask[SlotCaret]       = pre_m || pre_caret;
    mask[SlotFinal]       = 1'b1;

    desc      = {mask, digit_bytes, final_byte};
    desc_push = accept && !squeeze;

    prev_was_newline_next = squeeze ? pwn : (!(cfg.show_tabs && is_tab) && is_nl);
    blank_line_seen_next  = squeeze ? bls : (is_nl && pwn);
    line_counter_next     = cnt;
    line_bcd_next         = bcd;
    if (!squeeze && numbered && cnt < Cap) begin
      line_counter_next = cnt + 1'b1;
      line_bcd_next     = bcd_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_was_newline <= 1'b1;
      blank_line_seen  <= 1'b0;
      line_counter     <= CounterBits'(1);
      line_bcd         <= (4*NUMBER_DIGITS)'(1);
    end else if (accept) begin
      prev_was_newline <= prev_was_newline_next;
      blank_line_seen  <= blank_line_seen_next;
      line_counter     <= line_counter_next;
      line_bcd         <= line_bcd_next;
    end
  end

endmodule

[hdl/tvf_back.sv]
// ----------------------------------------------------------------------------
// tvf_back
// Takes descriptors from the queue and sends their display bytes, one per
// transfer, flagging the final byte of each run.
// ----------------------------------------------------------------------------
module tvf_back
  import tvf_pkg::*;
#(
  parameter int NUMBER_DIGITS = DefaultDigits,
  parameter int SLOTS         = NUMBER_DIGITS + 6,
  parameter int DESC_BITS     = SLOTS + 8 * NUMBER_DIGITS + 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [DESC_BITS-1:0] desc,
  input  logic                 desc_empty,
  output logic                 desc_pop,
  output logic                 empty,
  input  logic                 pop,
  output logic [7:0]           out_byte,
  output logic                 last_of_run
);

  localparam int SlotTab    = NUMBER_DIGITS;
  localparam int SlotDollar = NUMBER_DIGITS + 1;
  localparam int SlotM      = NUMBER_DIGITS + 2;
  localparam int SlotDash   = NUMBER_DIGITS + 3;
  localparam int SlotCaret  = NUMBER_DIGITS + 4;
  localparam int SlotBits   = $clog2(SLOTS);

  logic [SLOTS-1:0]           remaining;
  logic [8*NUMBER_DIGITS-1:0] digit_bytes;
  logic [7:0]                 final_byte;
  logic [SLOTS-1:0]           remaining_rest;
  logic [SlotBits-1:0]        slot;
  logic                       take;

  always_comb begin
    slot = '0;
    for (int s = SLOTS - 1; s >= 0; s--) begin
      if (remaining[s]) begin
        slot = SlotBits'(s);
      end
    end

    out_byte = final_byte;
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      if (slot == SlotBits'(i)) begin
        out_byte = digit_bytes[8*i +: 8];
      end
    end
    if (slot == SlotBits'(SlotTab)) begin
      out_byte = CharTab;
    end else if (slot == SlotBits'(SlotDollar)) begin
      out_byte = CharDollar;
    end else if (slot == SlotBits'(SlotM)) begin
      out_byte = CharM;
    end else if (slot == SlotBits'(SlotDash)) begin
      out_byte = CharDash;
    end else if (slot == SlotBits'(SlotCaret)) begin
      out_byte = CharCaret;
    end

    remaining_rest = remaining & (remaining - 1'b1);
    empty          = (remaining == '0);
    last_of_run    = (remaining_rest == '0);
    take           = empty || (pop && last_of_run);
    desc_pop       = take && !desc_empty;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= '0;
    end else if (take) begin
      remaining <= desc_empty ? '0 : desc[DESC_BITS-1 -: SLOTS];
    end else if (pop) begin
      remaining <= remaining_rest;
    end
  end

  always_ff @(posedge clk) begin
    if (desc_pop) begin
      digit_bytes <= desc[8 +: 8*NUMBER_DIGITS];
      final_byte  <= desc[7:0];
    end
  end

endmodule

[hdl/text_view_filter.sv]
// ----------------------------------------------------------------------------
// text_view_filter
// Display filter of a cat-like text viewer: line numbering, blank line
// squeezing, line end marks and caret notation for control bytes.
// ----------------------------------------------------------------------------
// Text bytes enter through a queue-like port: a transfer happens when push is
// high and full is low. Display bytes leave the same way: out_byte and
// last_of_run are valid while empty is low and a transfer happens when pop is
// high. Every input byte gives from one to NUMBER_DIGITS + 5 display bytes,
// or none when it is a squeezed blank line; last_of_run marks the final byte
// of each run. The first display byte of an input is shown once it has passed
// the queue and been loaded into the output sequencer. Bytes that expand to
// one display byte flow at one per cycle while pop is high; the rate is set by
// the output sequencer, which sends one byte per cycle unless the receiver
// stalls. A queue of four classified items lets input transfers carry on while
// the receiver stalls; full rises once it is filled. The user must see that
// the modes are written through the APB port only while the block is idle;
// the block does not enforce it. Reset clears the modes, the line state, the
// line counter (back to one) and the queue; no clearing pass follows it.
// ----------------------------------------------------------------------------
module text_view_filter
  import tvf_pkg::*;
#(
  parameter int NUMBER_DIGITS = DefaultDigits
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [AddrBits-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic                push,
  output logic                full,
  input  logic [7:0]          in_byte,
  input  logic                first_of_file,
  output logic                empty,
  input  logic                pop,
  output logic [7:0]          out_byte,
  output logic                last_of_run
);

  localparam int Slots    = NUMBER_DIGITS + 6;
  localparam int DescBits = Slots + 8 * NUMBER_DIGITS + 8;

  cfg_t                    cfg;
  logic [RegIndexBits-1:0] reg_index;
  logic                    reg_write;
  logic                    accept;
  logic                    q_push;
  logic [DescBits-1:0]     q_wdata;
  logic                    q_pop;
  logic [DescBits-1:0]     q_rdata;
  logic                    q_empty;

  assign pready    = 1'b1;
  assign reg_index = paddr[AddrBits-1:2];
  assign reg_write = psel && penable && pwrite && pready;
  assign accept    = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (reg_write) begin
      unique case (reg_index)
        RegNumberAll:      cfg.number_all_lines      <= pwdata[0];
        RegNumberNonblank: cfg.number_nonblank_lines <= pwdata[0];
        RegSqueezeBlank:   cfg.squeeze_blank         <= pwdata[0];
        RegMarkLineEnds:   cfg.mark_line_ends        <= pwdata[0];
        RegShowTabs:       cfg.show_tabs             <= pwdata[0];
        RegShowNonprint:   cfg.show_nonprinting      <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_index)
      RegNumberAll:      prdata[0] = cfg.number_all_lines;
      RegNumberNonblank: prdata[0] = cfg.number_nonblank_lines;
      RegSqueezeBlank:   prdata[0] = cfg.squeeze_blank;
      RegMarkLineEnds:   prdata[0] = cfg.mark_line_ends;
      RegShowTabs:       prdata[0] = cfg.show_tabs;
      RegShowNonprint:   prdata[0] = cfg.show_nonprinting;
      default:           prdata    = '0;
    endcase
  end

  tvf_front #(
    .NUMBER_DIGITS(NUMBER_DIGITS),
    .SLOTS        (Slots),
    .DESC_BITS    (DescBits)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .accept       (accept),
    .in_byte      (in_byte),
    .first_of_file(first_of_file),
    .desc_push    (q_push),
    .desc         (q_wdata)
  );

  tvf_queue #(
    .WIDTH(DescBits),
    .DEPTH(QueueDepth)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .wdata(q_wdata),
    .full (full),
    .pop  (q_pop),
    .rdata(q_rdata),
    .empty(q_empty)
  );

  tvf_back #(
    .NUMBER_DIGITS(NUMBER_DIGITS),
    .SLOTS        (Slots),
    .DESC_BITS    (DescBits)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .desc       (q_rdata),
    .desc_empty (q_empty),
    .desc_pop   (q_pop),
    .empty      (empty),
    .pop        (pop),
    .out_byte   (out_byte),
    .last_of_run(last_of_run)
  );

`ifndef SYNTH
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && !last_of_run) |=> !empty)
    else $error("display run ended before its final byte");

  a_item_reaches_output: assert property (@(posedge clk) disable iff (rst)
    q_push |=> ##1 !empty)
    else $error("classified item did not reach the output");

  a_full_means_busy: assert property (@(posedge clk) disable iff (rst)
    full |-> !empty)
    else $error("queue full while the output sequencer is idle");
`endif

endmodule

[verif/text_view_filter_tb.sv]
// ----------------------------------------------------------------------------
// text_view_filter_tb
// Self-checking bench for the text view filter. A queue of text bytes feeds a
// driver that offers them at random gaps. Each accepted byte is run through a
// local copy of the display rules to give the expected display bytes. A
// monitor pops the output at random stalls and checks every transfer against
// the oldest expected byte. Phases change the modes over the APB port while
// the block is idle. One phase has no idling on either side, and in another
// the receiver holds off for a long stretch so that the block fills up.
// ----------------------------------------------------------------------------
module text_view_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tvf_pkg::*;

  localparam int Digits      = DefaultDigits;
  localparam int LineCap     = (10 ** Digits) - 1 > (1 << CounterBits) - 1 ?
                               (1 << CounterBits) - 1 : (10 ** Digits) - 1;
  localparam int IdlePercent = 28;
  localparam int HoldCycles  = 150;
  localparam int DrainCycles = 16;
  localparam int CycleLimit  = 200000;
  localparam int PhaseItems  = 26;
  localparam logic [RegIndexBits-1:0] RegUnused = RegIndexBits'(RegCount);

  typedef struct packed {
    logic [7:0] b;
    logic       last;
  } disp_t;

  typedef struct packed {
    logic [7:0] b;
    logic       fresh;
  } text_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [AddrBits-1:0] paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;
  logic                push = 1'b0;
  logic                full;
  logic [7:0]          in_byte = '0;
  logic                first_of_file = 1'b0;
  logic                empty;
  logic                pop = 1'b0;
  logic [7:0]          out_byte;
  logic                last_of_run;

  text_t       text_in_q[$];
  disp_t       display_due[$];
  disp_t       due_now;
  cfg_t        mode = '0;
  logic        nl_prev = 1'b1;
  logic        blank_seen = 1'b0;
  logic [19:0] line_no = 20'd1;
  logic        took = 1'b0;
  logic        calm = 1'b0;
  int          hold_gen = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int          failures = 0;
  int          cycle_count = 0;

  text_view_filter dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .push         (push),
    .full         (full),
    .in_byte      (in_byte),
    .first_of_file(first_of_file),
    .empty        (empty),
    .pop          (pop),
    .out_byte     (out_byte),
    .last_of_run  (last_of_run)
  );

  always #6 clk = ~clk;

  function automatic void filter_byte(input logic [7:0] ch, input logic fresh);
    logic [7:0]  run[$];
    logic [19:0] v;
    logic        is_nl;
    logic        is_tab;
    logic [7:0]  c;
    disp_t       d;
    c = ch;
    is_nl = (ch == CharNl);
    is_tab = (ch == CharTab);
    if (fresh) begin
      nl_prev = 1'b1;
      blank_seen = 1'b0;
      line_no = 20'd1;
    end
    if (mode.squeeze_blank && is_nl && nl_prev && blank_seen) begin
      return;
    end
    blank_seen = is_nl && nl_prev;
    if (nl_prev && ((mode.number_all_lines && !mode.number_nonblank_lines) ||
                    (mode.number_nonblank_lines && !is_nl))) begin
      v = line_no;
      for (int i = 0; i < Digits; i++) begin
        if (i == 0 || v != 0) begin
          run.push_front(CharZero + 8'(v % 10));
        end else begin
          run.push_front(CharSpace);
        end
        v = v / 10;
      end
      run.push_back(CharTab);
      if (line_no < LineCap) begin
        line_no = line_no + 20'd1;
      end
    end
    if (mode.mark_line_ends && is_nl) begin
      run.push_back(CharDollar);
    end
    if (mode.show_tabs && is_tab) begin
      run.push_back(CharCaret);
      run.push_back(CharI);
      nl_prev = 1'b0;
    end else begin
      if (mode.show_nonprinting && !is_nl && !is_tab) begin
        if (c >= CharMeta && c < CharHigh) begin
          run.push_back(CharM);
          run.push_back(CharDash);
          run.push_back(CharCaret);
          c = c - CharOffset;
        end else if (c < CharSpace) begin
          run.push_back(CharCaret);
          c = c + CharOffset;
        end else if (c == CharDel) begin
          run.push_back(CharCaret);
          c = CharQuery;
        end
      end
      run.push_back(c);
      nl_prev = is_nl;
    end
    foreach (run[k]) begin
      d.b = run[k];
      d.last = (k == run.size() - 1);
      display_due.push_back(d);
    end
  endfunction

  function automatic logic [7:0] pick_text_byte();
    int r;
    r = $urandom_range(99);
    if (r < 18) return CharNl;
    if (r < 26) return CharTab;
    if (r < 34) return 8'($urandom_range(31));
    if (r < 38) return CharDel;
    if (r < 46) return 8'($urandom_range(159, 128));
    if (r < 54) return 8'($urandom_range(255, 160));
    return 8'($urandom_range(126, 32));
  endfunction

  task automatic queue_byte(input logic [7:0] b, input logic fresh);
    text_t t;
    t.b = b;
    t.fresh = fresh;
    text_in_q.push_back(t);
  endtask

  task automatic cfg_write(input logic [RegIndexBits-1:0] idx, input logic val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {31'($urandom), val};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      RegNumberAll:      mode.number_all_lines = val;
      RegNumberNonblank: mode.number_nonblank_lines = val;
      RegSqueezeBlank:   mode.squeeze_blank = val;
      RegMarkLineEnds:   mode.mark_line_ends = val;
      RegShowTabs:       mode.show_tabs = val;
      RegShowNonprint:   mode.show_nonprinting = val;
      default: ;
    endcase
  endtask

  task automatic apply_modes(input logic [5:0] m);
    cfg_write(RegNumberAll, m[0]);
    cfg_write(RegNumberNonblank, m[1]);
    cfg_write(RegSqueezeBlank, m[2]);
    cfg_write(RegMarkLineEnds, m[3]);
    cfg_write(RegShowTabs, m[4]);
    cfg_write(RegShowNonprint, m[5]);
    @(posedge clk);
  endtask

  task automatic wait_idle();
    do begin
      @(posedge clk);
    end while (text_in_q.size() != 0 || push || display_due.size() != 0);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Driver: holds each item until its transfer, then loads the next one.
  always @(negedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else if (!push || took) begin
      if (text_in_q.size() != 0 && (calm || $urandom_range(99) >= IdlePercent)) begin
        push <= 1'b1;
        in_byte <= text_in_q[0].b;
        first_of_file <= text_in_q[0].fresh;
        void'(text_in_q.pop_front());
      end else begin
        push <= 1'b0;
        in_byte <= 8'($urandom);
        first_of_file <= 1'($urandom);
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_gen != hold_seen) begin
      hold_seen <= hold_gen;
      hold_left <= HoldCycles;
      pop <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      pop <= 1'b0;
    end else begin
      pop <= calm || ($urandom_range(99) >= IdlePercent);
    end
  end

  always @(posedge clk) begin
    took <= push && !full;
    if (!rst && pop && !empty) begin
      if (display_due.size() == 0) begin
        $error("out_byte: expected nothing, actual %0d", out_byte);
        failures = failures + 1;
      end else begin
        due_now = display_due.pop_front();
        if (out_byte !== due_now.b) begin
          $error("out_byte: expected %0d, actual %0d", due_now.b, out_byte);
          failures = failures + 1;
        end
        if (last_of_run !== due_now.last) begin
          $error("last_of_run: expected %0d, actual %0d", due_now.last, last_of_run);
          failures = failures + 1;
        end
      end
    end
    if (!rst && push && !full) begin
      filter_byte(in_byte, first_of_file);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Squeezing, numbering and every kind of notation at once.
    apply_modes(6'b111101);
    cfg_write(RegUnused, 1'b1);
    @(posedge clk);
    queue_byte("a", 1'b1);
    queue_byte(CharTab, 1'b0);
    queue_byte(8'd0, 1'b0);
    queue_byte(8'd31, 1'b0);
    queue_byte(CharDel, 1'b0);
    queue_byte(CharMeta, 1'b0);
    queue_byte(8'd159, 1'b0);
    queue_byte(CharHigh, 1'b0);
    queue_byte(8'd255, 1'b0);
    queue_byte(CharNl, 1'b0);
    queue_byte(CharNl, 1'b0);
    queue_byte(CharNl, 1'b0);
    queue_byte(CharNl, 1'b0);
    queue_byte("z", 1'b0);
    queue_byte(CharNl, 1'b0);
    wait_idle();

    // Both numbering modes together, and a raw tab under caret notation.
    apply_modes(6'b100011);
    queue_byte(CharNl, 1'b1);
    queue_byte(CharNl, 1'b0);
    queue_byte(CharTab, 1'b0);
    queue_byte("b", 1'b0);
    queue_byte(8'd126, 1'b0);
    queue_byte(CharSpace, 1'b0);
    queue_byte(CharNl, 1'b0);
    queue_byte(8'd155, 1'b0);
    wait_idle();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: apply_modes(6'b000000);
        1: apply_modes(6'b111111);
        default: apply_modes(6'($urandom_range(63)));
      endcase
      calm = (phase == 2);
      if (phase == 3) begin
        hold_gen = hold_gen + 1;
      end
      for (int n = 0; n < PhaseItems; n++) begin
        queue_byte(pick_text_byte(), $urandom_range(99) < 4);
      end
      wait_idle();
      calm = 1'b0;
    end

    if (failures == 0 && display_due.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
